### hw/rtl/lrpc_pkg.sv
// lrpc_pkg: shared types, register indexes and reset values for the line rover patrol controller
// no dependencies
`timescale 1ns / 1ps

package lrpc_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int NOW_W   = 32;
  localparam int ECHO_W  = 15;
  localparam int GUARD_W = 16;
  localparam int ZONE_W  = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // input tdata layout
  localparam int IN_DATA_W = 56;
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_LEFT_BIT   = 32;
  localparam int IN_CENTER_BIT = 33;
  localparam int IN_RIGHT_BIT  = 34;
  localparam int IN_START_BIT  = 35;
  localparam int IN_STOP_BIT   = 36;
  localparam int IN_MARKER_BIT = 37;
  localparam int IN_ECHO_LSB   = 38;

  // output tdata layout
  localparam int OUT_DATA_W = 24;
  localparam int OUT_MODE_LSB    = 0;
  localparam int OUT_MLEFT_BIT   = 2;
  localparam int OUT_MRIGHT_BIT  = 3;
  localparam int OUT_LAMP_BIT    = 4;
  localparam int OUT_BUZZ_BIT    = 5;
  localparam int OUT_ACTION_LSB  = 6;
  localparam int OUT_ZONE_LSB    = 9;
  localparam int OUT_STROBE_BIT  = 13;
  localparam int OUT_PLANT_LSB   = 14;
  localparam int OUT_OBST_BIT    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_GUARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_GUARD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_TOTAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INSPECT_ZONE = 3'd4;

  // register reset values
  localparam logic [GUARD_W-1:0] BUTTON_GUARD_RST = 16'd150;
  localparam logic [GUARD_W-1:0] MARKER_GUARD_RST = 16'd1500;
  localparam logic [ECHO_W-1:0]  ECHO_LIMIT_RST   = 15'd583;
  localparam logic [ZONE_W-1:0]  ZONE_TOTAL_RST   = 4'd3;
  localparam logic [ZONE_W-1:0]  INSPECT_ZONE_RST = 4'd2;

  // mode codes as seen on the output
  localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_CODE_PATROL   = 2'd1;
  localparam logic [1:0] MODE_CODE_ZONE     = 2'd2;
  localparam logic [1:0] MODE_CODE_OBSTACLE = 2'd3;

  // action codes
  localparam logic [2:0] ACT_STOP    = 3'd0;
  localparam logic [2:0] ACT_FORWARD = 3'd1;
  localparam logic [2:0] ACT_LEFT    = 3'd2;
  localparam logic [2:0] ACT_RIGHT   = 3'd3;
  localparam logic [2:0] ACT_LOST    = 3'd4;
  localparam logic [2:0] ACT_CAPTURE = 3'd5;

  // plant status codes
  localparam logic [1:0] PLANT_UNKNOWN = 2'd0;
  localparam logic [1:0] PLANT_NORMAL  = 2'd1;
  localparam logic [1:0] PLANT_INSPECT = 2'd2;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic              line_left;
    logic              line_center;
    logic              line_right;
    logic              start_press;
    logic              stop_press;
    logic              marker_seen;
    logic [ECHO_W-1:0] echo_us;
  } item_t;

  typedef struct packed {
    logic [GUARD_W-1:0] button_guard_ms;
    logic [GUARD_W-1:0] marker_guard_ms;
    logic [ECHO_W-1:0]  echo_limit_us;
    logic [ZONE_W-1:0]  zone_total;
    logic [ZONE_W-1:0]  inspect_zone;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              motor_left;
    logic              motor_right;
    logic              status_lamp;
    logic              buzzer_on;
    logic [2:0]        action;
    logic [ZONE_W-1:0] zone_now;
    logic              capture_strobe;
    logic [1:0]        plant_status;
    logic              obstacle_flag;
  } result_t;

endpackage

### hw/rtl/lrpc_cfg.sv
// lrpc_cfg: configuration register file, written through a plain write port
// depends on lrpc_pkg
`timescale 1ns / 1ps

module lrpc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lrpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrpc_pkg::CFG_W-1:0]        cfg_data,
  output lrpc_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_guard_ms <= lrpc_pkg::BUTTON_GUARD_RST;
      cfg.marker_guard_ms <= lrpc_pkg::MARKER_GUARD_RST;
      cfg.echo_limit_us   <= lrpc_pkg::ECHO_LIMIT_RST;
      cfg.zone_total      <= lrpc_pkg::ZONE_TOTAL_RST;
      cfg.inspect_zone    <= lrpc_pkg::INSPECT_ZONE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lrpc_pkg::REG_BUTTON_GUARD: cfg.button_guard_ms <= cfg_data;
        lrpc_pkg::REG_MARKER_GUARD: cfg.marker_guard_ms <= cfg_data;
        lrpc_pkg::REG_ECHO_LIMIT:   cfg.echo_limit_us <= cfg_data[lrpc_pkg::ECHO_W-1:0];
        lrpc_pkg::REG_ZONE_TOTAL:   cfg.zone_total <= cfg_data[lrpc_pkg::ZONE_W-1:0];
        lrpc_pkg::REG_INSPECT_ZONE: cfg.inspect_zone <= cfg_data[lrpc_pkg::ZONE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/lrpc_step.sv
// lrpc_step: per-tick control step, holds mode, debounce stamps, zone and plant state
// and registers the result of each tick; depends on lrpc_pkg
`timescale 1ns / 1ps

module lrpc_step #(
  parameter int TIME_BITS = lrpc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  lrpc_pkg::item_t     item,
  input  lrpc_pkg::cfg_t      cfg,
  output lrpc_pkg::result_t   result
);

  typedef enum logic [1:0] {
    IDLE     = 2'd0,
    PATROL   = 2'd1,
    ZONE     = 2'd2,
    OBSTACLE = 2'd3
  } mode_t;

  mode_t                            mode_reg, mode_next, mode_btn;
  logic [TIME_BITS-1:0]             btn_stamp, btn_stamp_next;
  logic [TIME_BITS-1:0]             mrk_stamp, mrk_stamp_next;
  logic [lrpc_pkg::ZONE_W-1:0]      zone_count, zone_count_next;
  logic [1:0]                       plant_reg, plant_next;
  logic                             lamp_reg, lamp_next, lamp_btn;

  logic [TIME_BITS-1:0]             now_t;
  logic [TIME_BITS-1:0]             btn_elapsed, mrk_elapsed;
  logic                             btn_ok, mrk_ok, obst;
  logic [lrpc_pkg::ZONE_W:0]        zone_inc;
  lrpc_pkg::result_t                result_next;

  assign now_t       = TIME_BITS'(item.now_ms);
  assign btn_elapsed = now_t - btn_stamp;
  assign mrk_elapsed = now_t - mrk_stamp;
  assign btn_ok      = btn_elapsed >= TIME_BITS'(cfg.button_guard_ms);
  assign mrk_ok      = item.marker_seen && (mrk_elapsed > TIME_BITS'(cfg.marker_guard_ms));
  assign obst        = (item.echo_us != '0) && (item.echo_us <= cfg.echo_limit_us);
  assign zone_inc    = {1'b0, zone_count} + 5'd1;

  always_comb begin
    mode_btn       = mode_reg;
    lamp_btn       = lamp_reg;
    btn_stamp_next = btn_stamp;
    mrk_stamp_next = mrk_stamp;
    zone_count_next = zone_count;
    plant_next     = plant_reg;
    result_next    = '0;
    result_next.action = lrpc_pkg::ACT_STOP;

    // buttons, stop wins
    if (btn_ok && item.stop_press) begin
      btn_stamp_next = now_t;
      mode_btn       = IDLE;
      lamp_btn       = 1'b0;
    end else if (btn_ok && item.start_press) begin
      btn_stamp_next = now_t;
      mode_btn       = PATROL;
      lamp_btn       = 1'b1;
    end

    mode_next = mode_btn;
    lamp_next = lamp_btn;
    if (obst && mode_btn == PATROL) begin
      mode_next = OBSTACLE;
    end

    unique case (mode_next)
      IDLE: begin
        lamp_next = 1'b0;
      end
      PATROL: begin
        lamp_next = 1'b1;
        priority if (item.line_center && !item.line_left && !item.line_right) begin
          result_next.motor_left  = 1'b1;
          result_next.motor_right = 1'b1;
          result_next.action      = lrpc_pkg::ACT_FORWARD;
        end else if (item.line_left && !item.line_center) begin
          result_next.motor_right = 1'b1;
          result_next.action      = lrpc_pkg::ACT_LEFT;
        end else if (item.line_right && !item.line_center) begin
          result_next.motor_left  = 1'b1;
          result_next.action      = lrpc_pkg::ACT_RIGHT;
        end else if (item.line_left && item.line_center && item.line_right) begin
          result_next.motor_left  = 1'b1;
          result_next.motor_right = 1'b1;
          result_next.action      = lrpc_pkg::ACT_FORWARD;
        end else begin
          result_next.action      = lrpc_pkg::ACT_LOST;
        end
        if (mrk_ok) begin
          mrk_stamp_next = now_t;
          if (zone_inc > {1'b0, cfg.zone_total}) begin
            zone_count_next = lrpc_pkg::ZONE_W'(1);
          end else begin
            zone_count_next = zone_inc[lrpc_pkg::ZONE_W-1:0];
          end
          mode_next = ZONE;
        end
      end
      ZONE: begin
        result_next.action         = lrpc_pkg::ACT_CAPTURE;
        result_next.capture_strobe = 1'b1;
        plant_next = (zone_count == cfg.inspect_zone) ? lrpc_pkg::PLANT_INSPECT
                                                      : lrpc_pkg::PLANT_NORMAL;
        mode_next  = PATROL;
      end
      OBSTACLE: begin
        lamp_next = 1'b1;
        if (obst) begin
          result_next.buzzer_on = 1'b1;
        end else begin
          mode_next = PATROL;
        end
      end
      default: ;
    endcase

    result_next.mode          = mode_next;
    result_next.status_lamp   = lamp_next;
    result_next.zone_now      = zone_count_next;
    result_next.plant_status  = plant_next;
    result_next.obstacle_flag = obst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= IDLE;
      btn_stamp  <= '0;
      mrk_stamp  <= '0;
      zone_count <= '0;
      plant_reg  <= lrpc_pkg::PLANT_UNKNOWN;
      lamp_reg   <= 1'b0;
    end else if (adv) begin
      mode_reg   <= mode_next;
      btn_stamp  <= btn_stamp_next;
      mrk_stamp  <= mrk_stamp_next;
      zone_count <= zone_count_next;
      plant_reg  <= plant_next;
      lamp_reg   <= lamp_next;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule

### hw/rtl/line_rover_patrol_controller_top.sv
// line_rover_patrol_controller_top: stream wrapper with input and result registers
// depends on lrpc_pkg, lrpc_cfg, lrpc_step
`timescale 1ns / 1ps

// One control tick per input transfer, one result transfer per tick. A new tick is
// taken every cycle while the result side keeps up: the input register and the result
// register form a two-stage pipeline, and the mode, debounce stamps and zone state are
// updated in the same cycle a tick moves from the input register into the result
// register. Time stamps are kept and compared modulo 2^TIME_BITS. Configuration writes
// are taken at any cycle and apply to ticks that reach the step logic afterwards.

module line_rover_patrol_controller_top #(
  parameter int TIME_BITS = lrpc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // now_ms[31:0], line_left, line_center, line_right, start_press, stop_press,
  // marker_seen, echo_us[14:0], zero pad
  input  logic [lrpc_pkg::IN_DATA_W-1:0]     s_tdata,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // mode[1:0], motor_left, motor_right, status_lamp, buzzer_on, action[2:0],
  // zone_now[3:0], capture_strobe, plant_status[1:0], obstacle_flag, zero pad
  output logic [lrpc_pkg::OUT_DATA_W-1:0]    m_tdata,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [lrpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrpc_pkg::CFG_W-1:0]         cfg_data
);

  lrpc_pkg::cfg_t     cfg;
  lrpc_pkg::item_t    in_item;
  lrpc_pkg::result_t  result;
  logic               in_valid;
  logic               adv;
  logic               s_xfer;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign s_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      in_valid <= s_xfer || (in_valid && !adv);
      m_tvalid <= adv || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_item.now_ms      <= s_tdata[lrpc_pkg::IN_NOW_LSB +: lrpc_pkg::NOW_W];
      in_item.line_left   <= s_tdata[lrpc_pkg::IN_LEFT_BIT];
      in_item.line_center <= s_tdata[lrpc_pkg::IN_CENTER_BIT];
      in_item.line_right  <= s_tdata[lrpc_pkg::IN_RIGHT_BIT];
      in_item.start_press <= s_tdata[lrpc_pkg::IN_START_BIT];
      in_item.stop_press  <= s_tdata[lrpc_pkg::IN_STOP_BIT];
      in_item.marker_seen <= s_tdata[lrpc_pkg::IN_MARKER_BIT];
      in_item.echo_us     <= s_tdata[lrpc_pkg::IN_ECHO_LSB +: lrpc_pkg::ECHO_W];
    end
  end

  lrpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrpc_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  assign m_tdata = {7'd0,
                    result.obstacle_flag,
                    result.plant_status,
                    result.capture_strobe,
                    result.zone_now,
                    result.action,
                    result.buzzer_on,
                    result.status_lamp,
                    result.motor_right,
                    result.motor_left,
                    result.mode};

endmodule

### hw/rtl/lrpc_checker.sv
// lrpc_checker: port-level assertions for the line rover patrol controller, bound to the top
// depends on lrpc_pkg and line_rover_patrol_controller_top
`timescale 1ns / 1ps

module lrpc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lrpc_pkg::OUT_DATA_W-1:0]    m_tdata
);

  logic [1:0] mode;
  logic [2:0] action;

  assign mode   = m_tdata[lrpc_pkg::OUT_MODE_LSB +: 2];
  assign action = m_tdata[lrpc_pkg::OUT_ACTION_LSB +: 3];

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // nothing left over from before reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // capture strobe only on the capture step, which returns to patrol
  a_capture: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[lrpc_pkg::OUT_STROBE_BIT] |->
      action == lrpc_pkg::ACT_CAPTURE && mode == lrpc_pkg::MODE_CODE_PATROL)
    else $error("capture strobe outside capture step");

  // buzzer only while staying in obstacle mode with an obstacle present
  a_buzz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[lrpc_pkg::OUT_BUZZ_BIT] |->
      mode == lrpc_pkg::MODE_CODE_OBSTACLE && m_tdata[lrpc_pkg::OUT_OBST_BIT])
    else $error("buzzer without obstacle");

  // idle means motors and lamp off
  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mode == lrpc_pkg::MODE_CODE_IDLE |->
      !m_tdata[lrpc_pkg::OUT_MLEFT_BIT] && !m_tdata[lrpc_pkg::OUT_MRIGHT_BIT] &&
      !m_tdata[lrpc_pkg::OUT_LAMP_BIT])
    else $error("motors or lamp on in idle");

endmodule

bind line_rover_patrol_controller_top lrpc_checker u_lrpc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
